// ===== design/wtsp_pkg.sv =====
`default_nettype none
package wtsp_pkg;

  localparam int unsigned SCREEN_W_DEF = 664;
  localparam int unsigned SCREEN_H_DEF = 1176;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam int unsigned NUM_CFG   = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 64;

  // clip values: three 48-bit floored products plus a 32-bit offset
  localparam int unsigned CLIP_W = 50;
  // a * 2^16 numerator
  localparam int unsigned NUM_W  = CLIP_W + 16;
  // quotient magnitudes at or above 2^QBITS saturate every screen result
  localparam int unsigned QBITS  = 33;

  localparam logic signed [CLIP_W-1:0] W_MIN_RAW = CLIP_W'(6553);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_R0_C01 = 4'd0,
    REG_R0_C23 = 4'd1,
    REG_R1_C01 = 4'd2,
    REG_R1_C23 = 4'd3,
    REG_R2_C01 = 4'd4,
    REG_R2_C23 = 4'd5,
    REG_R3_C01 = 4'd6,
    REG_R3_C23 = 4'd7
  } cfg_reg_e;

  // one classified point between front and back
  typedef struct packed {
    logic              visible;
    logic              neg_x;
    logic              neg_y;
    logic [CLIP_W-1:0] mag_x;
    logic [CLIP_W-1:0] mag_y;
    logic [CLIP_W-1:0] w;
  } proj_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// ===== design/wtsp_front.sv =====
`default_nettype none
module wtsp_front
  import wtsp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [31:0]   pos_x_i,
  input  wire logic signed [31:0]   pos_y_i,
  input  wire logic signed [31:0]   pos_z_i,
  input  wire queue_status_t        q_status_i,
  output logic                      push_o,
  output proj_item_t                item_o
);

  logic [CFG_W-1:0] cfg_q [NUM_CFG];

  // rows used for clip x, y, w
  logic signed [31:0] coef [3][4];

  logic                      va_q, vb_q, vc_q;
  logic signed [63:0]        prod_q [3][3];
  logic signed [31:0]        off_q  [3];
  logic signed [CLIP_W-1:0]  clip_q [3];
  proj_item_t                item_q;
  logic                      adv;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = cfg_q[(r == 2) ? 6 : 2*r][31:0];
      coef[r][1] = cfg_q[(r == 2) ? 6 : 2*r][63:32];
      coef[r][2] = cfg_q[(r == 2) ? 7 : 2*r+1][31:0];
      coef[r][3] = cfg_q[(r == 2) ? 7 : 2*r+1][63:32];
    end
  end

  assign adv        = !(vc_q && q_status_i.full);
  assign in_stall_o = !adv;
  assign push_o     = vc_q && !q_status_i.full;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_R0_C01: cfg_q[0] <= cfg_data_i;
        REG_R0_C23: cfg_q[1] <= cfg_data_i;
        REG_R1_C01: cfg_q[2] <= cfg_data_i;
        REG_R1_C23: cfg_q[3] <= cfg_data_i;
        REG_R2_C01: cfg_q[4] <= cfg_data_i;
        REG_R2_C23: cfg_q[5] <= cfg_data_i;
        REG_R3_C01: cfg_q[6] <= cfg_data_i;
        REG_R3_C23: cfg_q[7] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= pos_x_i * coef[r][0];
        prod_q[r][1] <= pos_y_i * coef[r][1];
        prod_q[r][2] <= pos_z_i * coef[r][2];
        off_q[r]     <= coef[r][3];
        // arithmetic shift floors each Q32.32 product to Q32.16
        clip_q[r] <= CLIP_W'(prod_q[r][0] >>> 16) + CLIP_W'(prod_q[r][1] >>> 16)
                   + CLIP_W'(prod_q[r][2] >>> 16) + CLIP_W'(off_q[r]);
      end
      item_q.visible <= clip_q[2] > W_MIN_RAW;
      item_q.neg_x   <= clip_q[0][CLIP_W-1];
      item_q.neg_y   <= clip_q[1][CLIP_W-1];
      item_q.mag_x   <= clip_q[0][CLIP_W-1] ? -clip_q[0] : clip_q[0];
      item_q.mag_y   <= clip_q[1][CLIP_W-1] ? -clip_q[1] : clip_q[1];
      item_q.w       <= clip_q[2];
    end
  end

endmodule
`default_nettype wire

// ===== design/wtsp_queue.sv =====
`default_nettype none
module wtsp_queue
  import wtsp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire proj_item_t item_i,
  input  wire logic    pop_i,
  output proj_item_t   item_o,
  output queue_status_t status_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  proj_item_t     mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;

  assign status_o.full  = cnt_q == CW'(DEPTH);
  assign status_o.empty = cnt_q == '0;
  assign item_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== design/wtsp_back.sv =====
`default_nettype none
module wtsp_back
  import wtsp_pkg::*;
#(
  parameter int unsigned SCREEN_W = SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = SCREEN_H_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire proj_item_t    item_i,
  input  wire queue_status_t q_status_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               visible_o,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o
);

  localparam int HW = SCREEN_W / 2;
  localparam int HH = SCREEN_H / 2;
  localparam logic signed [14:0] FX = 15'(HW + 1);
  localparam logic signed [14:0] FY = 15'(1 - HH);
  localparam logic signed [CLIP_W-1:0] OFS_X = CLIP_W'(HW * 65536);
  localparam logic signed [CLIP_W-1:0] OFS_Y = CLIP_W'(HH * 65536);
  localparam int NS = QBITS + 1;

  // long-division stages, one quotient bit per stage
  logic              v_q    [NS];
  logic              vis_q  [NS];
  logic              nx_q   [NS];
  logic              ny_q   [NS];
  logic              ox_q   [NS];
  logic              oy_q   [NS];
  logic [NUM_W-1:0]  rx_q   [NS];
  logic [NUM_W-1:0]  ry_q   [NS];
  logic [QBITS-1:0]  qx_q   [NS];
  logic [QBITS-1:0]  qy_q   [NS];
  logic [CLIP_W-1:0] d_q    [NS];
  logic              gx     [NS-1];
  logic              gy     [NS-1];

  logic                     vm_q, vism_q;
  logic signed [CLIP_W-1:0] px_q, py_q;
  logic signed [QBITS+1:0]  ndc_x, ndc_y;
  logic signed [CLIP_W-1:0] sx, sy;
  logic                     ov_q, ovis_q;
  logic signed [31:0]       osx_q, osy_q;
  logic                     adv;

  function automatic logic signed [31:0] sat32(logic signed [CLIP_W-1:0] v);
    if (v > CLIP_W'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -CLIP_W'(33'sh080000000)) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign adv   = !(ov_q && out_stall_i);
  assign pop_o = adv && !q_status_i.empty;

  always_comb begin
    for (int k = 0; k < NS - 1; k++) begin
      gx[k] = (rx_q[k] >> (QBITS - 1 - k)) >= NUM_W'(d_q[k]);
      gy[k] = (ry_q[k] >> (QBITS - 1 - k)) >= NUM_W'(d_q[k]);
    end
    ndc_x = ox_q[NS-1] ? (QBITS+2)'(1) << QBITS : (QBITS+2)'(qx_q[NS-1]);
    ndc_y = oy_q[NS-1] ? (QBITS+2)'(1) << QBITS : (QBITS+2)'(qy_q[NS-1]);
    if (nx_q[NS-1]) ndc_x = -ndc_x;
    if (ny_q[NS-1]) ndc_y = -ndc_y;
    sx = px_q + OFS_X;
    sy = py_q + OFS_Y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) v_q[k] <= 1'b0;
      vm_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= !q_status_i.empty;
      for (int k = 1; k < NS; k++) v_q[k] <= v_q[k-1];
      vm_q <= v_q[NS-1];
      ov_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q[0] <= item_i.visible;
      nx_q[0]  <= item_i.neg_x;
      ny_q[0]  <= item_i.neg_y;
      d_q[0]   <= item_i.w;
      rx_q[0]  <= {item_i.mag_x, 16'b0};
      ry_q[0]  <= {item_i.mag_y, 16'b0};
      // quotient would reach 2^QBITS: result saturates anyway
      ox_q[0]  <= (item_i.mag_x >> (QBITS - 16)) >= item_i.w;
      oy_q[0]  <= (item_i.mag_y >> (QBITS - 16)) >= item_i.w;
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      for (int k = 0; k < NS - 1; k++) begin
        vis_q[k+1] <= vis_q[k];
        nx_q[k+1]  <= nx_q[k];
        ny_q[k+1]  <= ny_q[k];
        d_q[k+1]   <= d_q[k];
        ox_q[k+1]  <= ox_q[k];
        oy_q[k+1]  <= oy_q[k];
        rx_q[k+1]  <= gx[k] ? rx_q[k] - (NUM_W'(d_q[k]) << (QBITS - 1 - k)) : rx_q[k];
        ry_q[k+1]  <= gy[k] ? ry_q[k] - (NUM_W'(d_q[k]) << (QBITS - 1 - k)) : ry_q[k];
        qx_q[k+1]  <= qx_q[k] | (QBITS'(gx[k]) << (QBITS - 1 - k));
        qy_q[k+1]  <= qy_q[k] | (QBITS'(gy[k]) << (QBITS - 1 - k));
      end
      vism_q <= vis_q[NS-1];
      px_q   <= ndc_x * FX;
      py_q   <= ndc_y * FY;
      ovis_q <= vism_q;
      osx_q  <= vism_q ? sat32(sx) : '0;
      osy_q  <= vism_q ? sat32(sy) : '0;
    end
  end

  assign out_valid_o = ov_q;
  assign visible_o   = ovis_q;
  assign screen_x_o  = osx_q;
  assign screen_y_o  = osy_q;

endmodule
`default_nettype wire

// ===== design/world_to_screen_projection_core.sv =====
`default_nettype none
// Projects one signed Q16.16 world point per cycle, while in_stall_o is low,
// through the matrix held in eight 64-bit registers and maps it to screen
// space. A point is multiplied, summed and classified in the front, held in
// the queue, then passes the back (a load stage and 33 one-bit stages of
// restoring division, x and y side by side, then viewport multiply and
// saturate). The user must write the registers only while idle; the block
// itself does not enforce this.
module world_to_screen_projection_core
  import wtsp_pkg::*;
#(
  parameter int unsigned SCREEN_W = SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = SCREEN_H_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic signed [31:0]   pos_x_i,
  input  wire logic signed [31:0]   pos_y_i,
  input  wire logic signed [31:0]   pos_z_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      visible_o,
  output logic signed [31:0]        screen_x_o,
  output logic signed [31:0]        screen_y_o
);

  queue_status_t q_status;
  proj_item_t    push_item, head_item;
  logic          push, pop;

  assign cfg_ready_o = 1'b1;

  wtsp_front u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .pos_x_i, .pos_y_i, .pos_z_i,
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (push_item)
  );

  wtsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  wtsp_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
    .clk_i, .rst_ni,
    .item_i     (head_item),
    .q_status_i (q_status),
    .pop_o      (pop),
    .out_valid_o, .out_stall_i,
    .visible_o, .screen_x_o, .screen_y_o
  );

`ifndef NO_ASSERTIONS
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !visible_o |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("hidden point with nonzero screen coordinates");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("queue read while empty");
`endif

endmodule
`default_nettype wire
